// ===== hdl/rcr_pkg.sv =====
// rcr_pkg: shared types and constants of the rain column renderer
// used by rcr_front, rcr_fifo, rcr_back and led_matrix_rain_column_renderer
`default_nettype none

package rcr_pkg;

    // fixed field widths
    localparam int COL_W      = 8;   // internal column width, wide enough for any column count
    localparam int HEAD_W     = 16;
    localparam int TAIL_W     = 11;  // 5 * 255 fits
    localparam int PROD_W     = 19;  // (tail - dist) * brightness
    localparam int Q_W        = 8;   // tail green level
    localparam int MOD_BITS   = 16;  // random value width
    localparam int MOD_PER_ST = 2;   // remainder bits resolved per front stage
    localparam int FRONT_ST   = MOD_BITS / MOD_PER_ST;
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // color constants
    localparam int HEAD_RED_MUL = 180;
    localparam int TAIL_MUL     = 5;
    localparam logic [HEAD_W-1:0] HEAD_MAX = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_SCALE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPAWN_RATE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_SPEED   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_FIRST  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LAST   = 3'd7;

    // pixel classes
    typedef enum logic [1:0] {
        PK_BLACK,
        PK_HEAD,
        PK_TAIL
    } t_pix_kind;

    // job passed from front to back
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             restart;
    } t_job;

    // derived configuration seen by front and back
    typedef struct packed {
        logic [6:0]        eff_w;
        logic [5:0]        eff_h;
        logic [7:0]        bright;
        logic [TAIL_W-1:0] tail;
        logic [7:0]        rate;
        logic [7:0]        speed;
        logic [7:0]        head_red;
        logic [15:0]       range_first;
        logic [15:0]       range_last;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hdl/led_matrix_rain_column_renderer.sv =====
// led_matrix_rain_column_renderer: top level, config registers, front, queue and back
// pixel path: 8 remainder stages, queue, head read, row step, multiply and 8 divider stages;
// one pixel per cycle while items are queued and pop keeps the output slot free
// items enter each cycle while full is low; eff height rows are made per item
// reset: synchronous active low, registers to defaults, all drop heads read as zero
// depends on rcr_pkg, rcr_front, rcr_fifo, rcr_back
`default_nettype none

module led_matrix_rain_column_renderer #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    // item input
    input  wire logic push,
    output logic      full,
    input  wire logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] i_column,
    input  wire logic [15:0] i_random_value,
    // result output
    output logic      empty,
    input  wire logic pop,
    output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] o_row,
    output logic [7:0] o_red_level,
    output logic [7:0] o_green_level,
    output logic [7:0] o_blue_level,
    output logic       o_last_row,
    // configuration write
    input  wire logic i_cfg_valid,
    output logic      o_cfg_ready,
    input  wire logic [rcr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rcr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [6:0]  r_width;
    logic [5:0]  r_height;
    logic [7:0]  r_bright;
    logic [7:0]  r_scale;
    logic [7:0]  r_rate;
    logic [7:0]  r_speed;
    logic [15:0] r_first;
    logic [15:0] r_last;

    rcr_pkg::t_cfg w_cfg;
    rcr_pkg::t_job w_f_job;
    rcr_pkg::t_job w_q_job;
    logic          w_cfg_we;
    logic          w_clr;
    logic          w_f_valid;
    logic          w_q_full;
    logic          w_q_valid;
    logic          w_q_pop;

    // derived settings, clamped and scaled
    function automatic rcr_pkg::t_cfg derive(
        logic [6:0] w, logic [5:0] h, logic [7:0] b, logic [7:0] sc,
        logic [7:0] rt, logic [7:0] sp, logic [15:0] rf, logic [15:0] rl);
        rcr_pkg::t_cfg c;
        logic [15:0]   x;
        logic [16:0]   s;
        logic [rcr_pkg::TAIL_W-1:0] t;
        if (w == '0) begin
            c.eff_w = 7'd1;
        end else if (32'(w) > MAX_COLUMNS) begin
            c.eff_w = 7'(MAX_COLUMNS);
        end else begin
            c.eff_w = w;
        end
        if (h == '0) begin
            c.eff_h = 6'd1;
        end else if (32'(h) > MAX_ROWS) begin
            c.eff_h = 6'(MAX_ROWS);
        end else begin
            c.eff_h = h;
        end
        // 180*b/255 by reciprocal, exact for every 8 bit b
        x = 16'(b) * 16'(rcr_pkg::HEAD_RED_MUL);
        s = 17'(x) + 17'(x[15:8]) + 17'd1;
        c.head_red = s[15:8];
        t = rcr_pkg::TAIL_W'(sc) * rcr_pkg::TAIL_W'(rcr_pkg::TAIL_MUL);
        c.tail        = (t == '0) ? rcr_pkg::TAIL_W'(1) : t;
        c.bright      = b;
        c.rate        = (rt == '0) ? 8'd1 : rt;
        c.speed       = (sp == '0) ? 8'd1 : sp;
        c.range_first = rf;
        c.range_last  = rl;
        return c;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign w_clr       = w_cfg_we && (i_cfg_index == rcr_pkg::REG_FRAME_WIDTH);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 7'd64;
            r_height <= 6'd32;
            r_bright <= 8'd255;
            r_scale  <= 8'd1;
            r_rate   <= 8'd1;
            r_speed  <= 8'd1;
            r_first  <= 16'd0;
            r_last   <= 16'hFFFF;
        end else if (w_cfg_we) begin
            unique case (i_cfg_index)
                rcr_pkg::REG_FRAME_WIDTH:  r_width  <= i_cfg_data[6:0];
                rcr_pkg::REG_FRAME_HEIGHT: r_height <= i_cfg_data[5:0];
                rcr_pkg::REG_BRIGHTNESS:   r_bright <= i_cfg_data[7:0];
                rcr_pkg::REG_TAIL_SCALE:   r_scale  <= i_cfg_data[7:0];
                rcr_pkg::REG_SPAWN_RATE:   r_rate   <= i_cfg_data[7:0];
                rcr_pkg::REG_FALL_SPEED:   r_speed  <= i_cfg_data[7:0];
                rcr_pkg::REG_RANGE_FIRST:  r_first  <= i_cfg_data;
                rcr_pkg::REG_RANGE_LAST:   r_last   <= i_cfg_data;
            endcase
        end
    end

    // derived settings, in effect right after the write edge
    assign w_cfg = derive(r_width, r_height, r_bright, r_scale,
                          r_rate, r_speed, r_first, r_last);

    rcr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_column    (rcr_pkg::COL_W'(i_column)),
        .i_random    (i_random_value),
        .i_cfg       (w_cfg),
        .o_job_valid (w_f_valid),
        .o_job       (w_f_job),
        .i_q_full    (w_q_full)
    );

    rcr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_job   (w_f_job),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    rcr_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_clr_heads   (w_clr),
        .i_job_valid   (w_q_valid),
        .i_job         (w_q_job),
        .o_job_pop     (w_q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_row         (o_row),
        .o_red_level   (o_red_level),
        .o_green_level (o_green_level),
        .o_blue_level  (o_blue_level),
        .o_last_row    (o_last_row)
    );

endmodule

`default_nettype wire

// ===== hdl/rcr_front.sv =====
// rcr_front: accepts column items, drops bad columns, works out the spawn decision
// pipelined restoring remainder, two bits per stage; depends on rcr_pkg
`default_nettype none

module rcr_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    output logic                          o_full,
    input  wire logic [rcr_pkg::COL_W-1:0] i_column,
    input  wire logic [rcr_pkg::MOD_BITS-1:0] i_random,
    input  wire rcr_pkg::t_cfg            i_cfg,
    output logic                          o_job_valid,
    output rcr_pkg::t_job                 o_job,
    input  wire logic                     i_q_full
);

    typedef struct packed {
        logic                          v;
        logic [rcr_pkg::COL_W-1:0]     col;
        logic [rcr_pkg::MOD_BITS-1:0]  bits;
        logic [7:0]                    rem;
    } t_fstage;

    localparam int LAST = rcr_pkg::FRONT_ST - 1;

    t_fstage r_fs [rcr_pkg::FRONT_ST];
    t_fstage n_fs [rcr_pkg::FRONT_ST];
    t_fstage w_in;
    logic    w_fen;

    // two restoring remainder steps, remainder stays below rate
    function automatic t_fstage mod_step2(t_fstage s, logic [7:0] rate);
        t_fstage    o;
        logic [8:0] r9;
        o = s;
        for (int i = 0; i < rcr_pkg::MOD_PER_ST; i++) begin
            r9     = {o.rem, o.bits[rcr_pkg::MOD_BITS-1]};
            o.bits = {o.bits[rcr_pkg::MOD_BITS-2:0], 1'b0};
            if (r9 >= {1'b0, rate}) begin
                o.rem = 8'(r9 - {1'b0, rate});
            end else begin
                o.rem = r9[7:0];
            end
        end
        return o;
    endfunction

    // whole pipe moves unless the last stage waits on the queue
    assign w_fen  = !(r_fs[LAST].v && i_q_full);
    assign o_full = !w_fen;

    // entry, columns outside the frame are accepted and dropped
    always_comb begin
        w_in.v    = i_push && ({1'b0, i_column} < 9'(i_cfg.eff_w));
        w_in.col  = i_column;
        w_in.bits = i_random;
        w_in.rem  = '0;
        n_fs[0]   = mod_step2(w_in, i_cfg.rate);
        for (int s = 1; s < rcr_pkg::FRONT_ST; s++) begin
            n_fs[s] = mod_step2(r_fs[s-1], i_cfg.rate);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < rcr_pkg::FRONT_ST; s++) begin
                r_fs[s] <= '0;
            end
        end else if (w_fen) begin
            for (int s = 0; s < rcr_pkg::FRONT_ST; s++) begin
                r_fs[s] <= n_fs[s];
            end
        end
    end

    // hand the job to the queue
    assign o_job_valid   = r_fs[LAST].v && !i_q_full;
    assign o_job.col     = r_fs[LAST].col;
    assign o_job.restart = (r_fs[LAST].rem == '0);

endmodule

`default_nettype wire

// ===== hdl/rcr_fifo.sv =====
// rcr_fifo: short job queue between front and back
// register based, depends on rcr_pkg
`default_nettype none

module rcr_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire rcr_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output rcr_pkg::t_job      o_job
);

    localparam int DEPTH = rcr_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    rcr_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH))
        else $error("job queue count beyond depth");

endmodule

`default_nettype wire

// ===== hdl/rcr_back.sv =====
// rcr_back: head memory, row sequencer and pixel pipeline with pipelined divider
// depends on rcr_pkg
`default_nettype none

module rcr_back #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rcr_pkg::t_cfg i_cfg,
    input  wire logic          i_clr_heads,
    input  wire logic          i_job_valid,
    input  wire rcr_pkg::t_job i_job,
    output logic               o_job_pop,
    output logic               o_empty,
    input  wire logic          i_pop,
    output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] o_row,
    output logic [7:0]         o_red_level,
    output logic [7:0]         o_green_level,
    output logic [7:0]         o_blue_level,
    output logic               o_last_row
);

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int YW  = RW + 1;
    localparam int CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int NST = 2 + rcr_pkg::Q_W;
    localparam int HW  = rcr_pkg::HEAD_W;

    typedef struct packed {
        logic                         v;
        logic [RW-1:0]                row;
        logic                         last;
        rcr_pkg::t_pix_kind           kind;
        logic [rcr_pkg::PROD_W-1:0]   rem;
        logic [rcr_pkg::Q_W-1:0]      q;
    } t_stage;

    // head memory and per-column valid bits
    logic [HW-1:0]          r_mem [MAX_COLUMNS];
    logic [MAX_COLUMNS-1:0] r_hv;

    // load slot
    logic                      r_ld_v;
    logic [rcr_pkg::COL_W-1:0] r_ld_col;
    logic                      r_ld_restart;
    logic [HW-1:0]             r_rd_data;
    logic                      r_rd_hv;
    logic                      r_ld_byp;
    logic [HW-1:0]             r_byp_data;

    // row sequencer
    logic          r_g_v;
    logic [HW-1:0] r_g_head;
    logic [RW-1:0] r_g_y;
    logic [HW-1:0] r_g_idx;

    t_stage r_st [NST];
    t_stage n_st [NST];

    logic                        w_ben;
    logic                        w_xfer;
    logic [HW-1:0]               w_ld_head;
    logic [HW:0]                 w_sum;
    logic [HW-1:0]               w_ld_next;
    logic [HW-1:0]               w_y16;
    logic [HW-1:0]               w_dist;
    logic                        w_last;
    logic                        w_inr;
    rcr_pkg::t_pix_kind          w_kind;
    logic [rcr_pkg::TAIL_W-1:0]  w_diff;

    // whole back end moves when the output slot is free or taken
    assign w_ben = !r_st[NST-1].v || i_pop;

    // head of the loaded column, with restart and same-edge bypass
    always_comb begin
        if (r_ld_restart) begin
            w_ld_head = '0;
        end else if (r_ld_byp) begin
            w_ld_head = r_byp_data;
        end else if (r_rd_hv) begin
            w_ld_head = r_rd_data;
        end else begin
            w_ld_head = '0;
        end
        w_sum     = {1'b0, w_ld_head} + (HW+1)'(i_cfg.speed);
        w_ld_next = w_sum[HW] ? rcr_pkg::HEAD_MAX : w_sum[HW-1:0];
    end

    // current row classification
    always_comb begin
        w_y16  = HW'(r_g_y);
        w_dist = r_g_head - w_y16;
        w_last = (({1'b0, r_g_y} + 1'b1) == YW'(i_cfg.eff_h));
        w_inr  = (r_g_idx >= i_cfg.range_first) && (r_g_idx <= i_cfg.range_last);
        w_diff = i_cfg.tail - w_dist[rcr_pkg::TAIL_W-1:0];
        w_kind = rcr_pkg::PK_BLACK;
        if (w_inr && (r_g_head >= w_y16)) begin
            if (w_dist == '0) begin
                w_kind = rcr_pkg::PK_HEAD;
            end else if (w_dist < HW'(i_cfg.tail)) begin
                w_kind = rcr_pkg::PK_TAIL;
            end
        end
    end

    assign w_xfer    = w_ben && r_ld_v && (!r_g_v || w_last);
    assign o_job_pop = w_ben && i_job_valid && (!r_ld_v || w_xfer);

    // memory read at pop, write of the advanced head at transfer
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_rd_data  <= r_mem[i_job.col[CW-1:0]];
            r_byp_data <= w_ld_next;
            r_ld_col   <= i_job.col;
            r_ld_restart <= i_job.restart;
        end
        if (w_xfer) begin
            r_mem[r_ld_col[CW-1:0]] <= w_ld_next;
        end
    end

    // head valid bits, cleared on reset and on any width write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr_heads) begin
            r_hv <= '0;
        end else if (w_xfer) begin
            r_hv[r_ld_col[CW-1:0]] <= 1'b1;
        end
    end

    // load slot control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_v   <= 1'b0;
            r_rd_hv  <= 1'b0;
            r_ld_byp <= 1'b0;
        end else if (o_job_pop) begin
            r_ld_v   <= 1'b1;
            r_rd_hv  <= r_hv[i_job.col[CW-1:0]];
            r_ld_byp <= w_xfer && (r_ld_col == i_job.col);
        end else if (w_xfer) begin
            r_ld_v <= 1'b0;
        end
    end

    // row sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v    <= 1'b0;
            r_g_head <= '0;
            r_g_y    <= '0;
            r_g_idx  <= '0;
        end else if (w_ben) begin
            if (w_xfer) begin
                r_g_v    <= 1'b1;
                r_g_head <= w_ld_head;
                r_g_y    <= '0;
                r_g_idx  <= HW'(r_ld_col);
            end else if (r_g_v) begin
                if (w_last) begin
                    r_g_v <= 1'b0;
                end else begin
                    r_g_y   <= r_g_y + 1'b1;
                    r_g_idx <= r_g_idx + HW'(i_cfg.eff_w);
                end
            end
        end
    end

    // pixel pipeline: multiply, then one quotient bit per stage
    always_comb begin
        logic [rcr_pkg::PROD_W-1:0] v_sh;
        n_st[0].v    = r_g_v;
        n_st[0].row  = r_g_y;
        n_st[0].last = w_last;
        n_st[0].kind = w_kind;
        n_st[0].rem  = rcr_pkg::PROD_W'(w_diff);
        n_st[0].q    = '0;
        n_st[1]      = r_st[0];
        n_st[1].rem  = rcr_pkg::PROD_W'(r_st[0].rem[rcr_pkg::TAIL_W-1:0])
                     * rcr_pkg::PROD_W'(i_cfg.bright);
        for (int s = 2; s < NST; s++) begin
            n_st[s] = r_st[s-1];
            v_sh = rcr_pkg::PROD_W'(i_cfg.tail) << (NST - 1 - s);
            if (r_st[s-1].rem >= v_sh) begin
                n_st[s].rem = r_st[s-1].rem - v_sh;
                n_st[s].q[NST-1-s] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) begin
                r_st[s] <= '0;
            end
        end else if (w_ben) begin
            for (int s = 0; s < NST; s++) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    // output colors
    always_comb begin
        o_red_level   = '0;
        o_green_level = '0;
        unique case (r_st[NST-1].kind)
            rcr_pkg::PK_HEAD: begin
                o_red_level   = i_cfg.head_red;
                o_green_level = i_cfg.bright;
            end
            rcr_pkg::PK_TAIL: begin
                o_green_level = r_st[NST-1].q;
            end
            default: begin
                o_red_level   = '0;
                o_green_level = '0;
            end
        endcase
    end

    assign o_blue_level = o_red_level;
    assign o_row        = r_st[NST-1].row;
    assign o_last_row   = r_st[NST-1].last;
    assign o_empty      = !r_st[NST-1].v;

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_g_v |-> ({1'b0, r_g_y} < YW'(i_cfg.eff_h)))
        else $error("row sequencer past frame height");

    a_tail_below_bright: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st[NST-1].v && (r_st[NST-1].kind == rcr_pkg::PK_TAIL))
        |-> ((r_st[NST-1].q < i_cfg.bright) || (i_cfg.bright == '0)))
        else $error("tail level not below brightness");

    a_bypass_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ld_v && r_ld_byp) |-> (r_byp_data != '0))
        else $error("bypassed head did not advance");

endmodule

`default_nettype wire
